/* sv/vec3_alu_defines.svh */
// assertion helpers shared by the checking code
`ifndef VEC3_ALU_DEFINES_SVH
`define VEC3_ALU_DEFINES_SVH

// same-cycle implication, checked outside reset
`define V3A_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define V3A_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/v3alu_pkg.sv */
package v3alu_pkg;

  localparam int DW        = 32;
  localparam int SQ_W      = 64;
  localparam int SQ_STAGES = SQ_W / 2;

  localparam logic [3:0] FN_NEG   = 4'd0;
  localparam logic [3:0] FN_ADD   = 4'd1;
  localparam logic [3:0] FN_SUB   = 4'd2;
  localparam logic [3:0] FN_DOT   = 4'd3;
  localparam logic [3:0] FN_CROSS = 4'd4;
  localparam logic [3:0] FN_SCALE = 4'd5;
  localparam logic [3:0] FN_DIV   = 4'd6;
  localparam logic [3:0] FN_LEN   = 4'd7;
  localparam logic [3:0] FN_NORM  = 4'd8;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  localparam logic [DW-1:0] SMAX = 32'h7fff_ffff;
  localparam logic [DW-1:0] SMIN = 32'h8000_0000;

  // scalar side data traveling with the square root
  typedef struct packed {
    logic [3:0]    func;
    logic [DW-1:0] sc;
    logic          sc_ovf;
    logic [DW-1:0] abs_s;
  } scal_t;

  // scalar side data traveling with the divider
  typedef struct packed {
    logic [3:0]    func;
    logic [DW-1:0] sc;
    logic          sc_ovf;
    logic          dz;
  } tail_t;

  // per-lane data carried down the pipe
  typedef struct packed {
    logic [DW-1:0] sres;
    logic          sovf;
    logic [DW-1:0] mag;
    logic          neg;
  } lcar_t;

  // per-lane final results handed to the merge stage
  typedef struct packed {
    logic [DW-1:0] sres;
    logic          sovf;
    logic [DW-1:0] qres;
    logic          qovf;
  } lres_t;

  // one result transaction
  typedef struct packed {
    logic [DW-1:0] rx;
    logic [DW-1:0] ry;
    logic [DW-1:0] rz;
    logic [DW-1:0] scalar_out;
    logic [1:0]    status;
  } res_t;

  // clamp a wide signed value to DW bits, msb of result flags the clamp
  function automatic logic [DW:0] sat65(input logic signed [2*DW:0] v);
    logic fits;
    fits = (&v[2*DW:DW-1]) || !(|v[2*DW:DW-1]);
    if (fits) begin
      return {1'b0, v[DW-1:0]};
    end
    return {1'b1, (v[2*DW] ? SMIN : SMAX)};
  endfunction

endpackage

/* sv/v3alu_ifs.sv */
interface v3alu_in_if import v3alu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [3:0]           func;
  logic signed [DW-1:0] ax;
  logic signed [DW-1:0] ay;
  logic signed [DW-1:0] az;
  logic signed [DW-1:0] bx;
  logic signed [DW-1:0] by_comp;
  logic signed [DW-1:0] bz;
  logic signed [DW-1:0] scalar_in;

  modport source (output valid, func, ax, ay, az, bx, by_comp, bz, scalar_in,
                  input ready);
  modport sink (input valid, func, ax, ay, az, bx, by_comp, bz, scalar_in,
                output ready);
endinterface

interface v3alu_out_if import v3alu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] rx;
  logic signed [DW-1:0] ry;
  logic signed [DW-1:0] rz;
  logic signed [DW-1:0] scalar_out;
  logic [1:0]           status;

  modport source (output valid, rx, ry, rz, scalar_out, status, input ready);
  modport sink (input valid, rx, ry, rz, scalar_out, status, output ready);
endinterface

/* sv/v3alu_sqrt.sv */
module v3alu_sqrt import v3alu_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [SQ_W-1:0] n_in,
  input  scal_t           side_in,
  output logic [DW-1:0]   len_out,
  output scal_t           side_out
);

  logic [SQ_W-1:0] rem_r  [SQ_STAGES];
  logic [SQ_W-1:0] res_r  [SQ_STAGES];
  scal_t           side_r [SQ_STAGES];

  // one result bit per stage, trial bit walks down two places a stage
  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stg
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] rem_in;
    logic [SQ_W-1:0] res_in;
    scal_t           side_stg;
    logic [SQ_W-1:0] trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in   = n_in;
      assign res_in   = '0;
      assign side_stg = side_in;
    end else begin : g_next
      assign rem_in   = rem_r[k-1];
      assign res_in   = res_r[k-1];
      assign side_stg = side_r[k-1];
    end

    assign trial = res_in + BIT;
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? rem_in - trial : rem_in;
        res_r[k]  <= ge ? (res_in >> 1) + BIT : res_in >> 1;
        side_r[k] <= side_stg;
      end
    end
  end

  // root of a sum of three squares stays below 2^32
  assign len_out  = res_r[SQ_STAGES-1][DW-1:0];
  assign side_out = side_r[SQ_STAGES-1];

endmodule

/* sv/v3alu_lane.sv */
module v3alu_lane import v3alu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [3:0]             func,
  input  logic signed [DW-1:0]   a_i,
  input  logic signed [DW-1:0]   b_i,
  input  logic signed [DW-1:0]   a_j,
  input  logic signed [DW-1:0]   b_k,
  input  logic signed [DW-1:0]   a_k,
  input  logic signed [DW-1:0]   b_j,
  input  logic signed [DW-1:0]   s,
  input  logic [DW-1:0]          div_d,
  output logic signed [2*DW-1:0] p1,
  output lres_t                  res
);

  localparam int QW = DW + FRAC_BITS;

  // stage 1: products and add/sub
  logic signed [DW-1:0]   m1a, m1b;
  logic signed [DW:0]     a_e, b_e, as_nxt;
  logic signed [2*DW-1:0] p1_r, p2_r;
  logic signed [DW:0]     as_r;
  logic [3:0]             func1_r;
  logic signed [DW-1:0]   a1_r;
  logic                   sneg1_r;

  assign a_e = {a_i[DW-1], a_i};
  assign b_e = {b_i[DW-1], b_i};

  always_comb begin
    case (func)
      FN_DOT:   begin m1a = a_i; m1b = b_i; end
      FN_LEN:   begin m1a = a_i; m1b = a_i; end
      FN_NORM:  begin m1a = a_i; m1b = a_i; end
      FN_SCALE: begin m1a = a_i; m1b = s;   end
      FN_CROSS: begin m1a = a_j; m1b = b_k; end
      default:  begin m1a = a_i; m1b = b_i; end
    endcase
    case (func)
      FN_NEG:  as_nxt = -a_e;
      FN_ADD:  as_nxt = a_e + b_e;
      FN_SUB:  as_nxt = a_e - b_e;
      default: as_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= m1a * m1b;
      p2_r    <= a_k * b_j;
      as_r    <= as_nxt;
      func1_r <= func;
      a1_r    <= a_i;
      sneg1_r <= s[DW-1];
    end
  end

  assign p1 = p1_r;

  // stage 2: cut back, saturate, split magnitude and sign for the divider
  logic signed [2*DW:0] p1_e, p2_e, cdiff, as_e;
  logic [DW:0]          cross_s, scale_s, as_s, simple_s;
  lcar_t                car2_nxt, car2_r;

  assign p1_e    = {p1_r[2*DW-1], p1_r};
  assign p2_e    = {p2_r[2*DW-1], p2_r};
  assign cdiff   = p1_e - p2_e;
  assign as_e    = {{DW{as_r[DW]}}, as_r};
  assign cross_s = sat65(cdiff >>> FRAC_BITS);
  assign scale_s = sat65(p1_e >>> FRAC_BITS);
  assign as_s    = sat65(as_e);

  always_comb begin
    case (func1_r)
      FN_NEG:   simple_s = as_s;
      FN_ADD:   simple_s = as_s;
      FN_SUB:   simple_s = as_s;
      FN_CROSS: simple_s = cross_s;
      FN_SCALE: simple_s = scale_s;
      default:  simple_s = '0;
    endcase
    car2_nxt.sres = simple_s[DW-1:0];
    car2_nxt.sovf = simple_s[DW];
    car2_nxt.mag  = a1_r[DW-1] ? -a1_r : a1_r;
    car2_nxt.neg  = a1_r[DW-1] ^ ((func1_r == FN_DIV) && sneg1_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      car2_r <= car2_nxt;
    end
  end

  // wait alongside the square root
  lcar_t car_r [SQ_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      car_r[0] <= car2_r;
      for (int k = 1; k < SQ_STAGES; k++) begin
        car_r[k] <= car_r[k-1];
      end
    end
  end

  // restoring divider, one quotient bit per stage
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] sh_r   [QW];
  logic [DW-1:0] d_r    [QW];
  lcar_t         dcar_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DW-1:0] rem_in, d_in;
    logic [QW-1:0] sh_in;
    lcar_t         car_in;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign sh_in  = {car_r[SQ_STAGES-1].mag, {FRAC_BITS{1'b0}}};
      assign d_in   = div_d;
      assign car_in = car_r[SQ_STAGES-1];
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign sh_in  = sh_r[k-1];
      assign d_in   = d_r[k-1];
      assign car_in = dcar_r[k-1];
    end

    assign t  = {rem_in, sh_in[QW-1]};
    assign ge = t >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? DW'(t - {1'b0, d_in}) : t[DW-1:0];
        sh_r[k]   <= {sh_in[QW-2:0], ge};
        d_r[k]    <= d_in;
        dcar_r[k] <= car_in;
      end
    end
  end

  // signed quotient with saturation
  logic [QW-1:0] q;
  logic          qneg, pos_ovf, neg_ovf, qovf;

  assign q       = sh_r[QW-1];
  assign qneg    = dcar_r[QW-1].neg;
  assign pos_ovf = |q[QW-1:DW-1];
  assign neg_ovf = (|q[QW-1:DW]) || (q[DW-1] && (|q[DW-2:0]));
  assign qovf    = qneg ? neg_ovf : pos_ovf;

  always_comb begin
    res.sres = dcar_r[QW-1].sres;
    res.sovf = dcar_r[QW-1].sovf;
    res.qovf = qovf;
    if (qovf) begin
      res.qres = qneg ? SMIN : SMAX;
    end else begin
      res.qres = qneg ? -q[DW-1:0] : q[DW-1:0];
    end
  end

endmodule

/* sv/v3alu_merge.sv */
module v3alu_merge import v3alu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [3:0]             func0,
  input  logic signed [DW-1:0]   s0,
  input  logic signed [2*DW-1:0] p1 [3],
  output logic [SQ_W-1:0]        dotaa,
  output scal_t                  side_o,
  input  logic [DW-1:0]          len_i,
  input  scal_t                  side_i,
  output logic [DW-1:0]          div_d,
  input  lres_t                  lres [3],
  output res_t                   fin
);

  localparam int QW = DW + FRAC_BITS;

  // stage 1: scalar operand magnitude
  logic [3:0]    func1_r;
  logic [DW-1:0] abs_s1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      func1_r  <= func0;
      abs_s1_r <= s0[DW-1] ? -s0 : s0;
    end
  end

  // stage 2: exact dot sum and sum of squares
  logic signed [2*DW+1:0] e0, e1, e2, dsum, dsh;
  logic [DW:0]            dot_s;
  logic [SQ_W-1:0]        dotaa_r;
  scal_t                  side2_nxt, side2_r;

  assign e0    = {{2{p1[0][2*DW-1]}}, p1[0]};
  assign e1    = {{2{p1[1][2*DW-1]}}, p1[1]};
  assign e2    = {{2{p1[2][2*DW-1]}}, p1[2]};
  assign dsum  = e0 + e1 + e2;
  assign dsh   = dsum >>> FRAC_BITS;
  assign dot_s = sat65(dsh[2*DW:0]);

  always_comb begin
    side2_nxt.func   = func1_r;
    side2_nxt.sc     = (func1_r == FN_DOT) ? dot_s[DW-1:0] : '0;
    side2_nxt.sc_ovf = (func1_r == FN_DOT) && dot_s[DW];
    side2_nxt.abs_s  = abs_s1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dotaa_r <= SQ_W'(p1[0]) + SQ_W'(p1[1]) + SQ_W'(p1[2]);
      side2_r <= side2_nxt;
    end
  end

  assign dotaa  = dotaa_r;
  assign side_o = side2_r;

  // after the root: divisor choice, zero check, length clamp
  logic  isdiv_i, lovf;
  tail_t tail0;
  tail_t tail_r [QW];

  assign div_d   = (side_i.func == FN_NORM) ? len_i : side_i.abs_s;
  assign isdiv_i = (side_i.func == FN_DIV) || (side_i.func == FN_NORM);
  assign lovf    = len_i[DW-1];

  always_comb begin
    tail0.func = side_i.func;
    tail0.dz   = isdiv_i && (div_d == '0);
    if (side_i.func == FN_LEN) begin
      tail0.sc     = lovf ? SMAX : len_i;
      tail0.sc_ovf = lovf;
    end else begin
      tail0.sc     = side_i.sc;
      tail0.sc_ovf = side_i.sc_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tail_r[0] <= tail0;
      for (int k = 1; k < QW; k++) begin
        tail_r[k] <= tail_r[k-1];
      end
    end
  end

  // final merge of lanes and status
  tail_t         tl;
  logic          isdiv, any_ovf;
  logic [DW-1:0] r [3];
  logic [2:0]    ovf;
  res_t          fin_nxt, fin_r;

  assign tl    = tail_r[QW-1];
  assign isdiv = (tl.func == FN_DIV) || (tl.func == FN_NORM);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (isdiv) begin
        r[i]   = tl.dz ? '0 : lres[i].qres;
        ovf[i] = !tl.dz && lres[i].qovf;
      end else begin
        r[i]   = lres[i].sres;
        ovf[i] = lres[i].sovf;
      end
    end
    any_ovf            = (|ovf) || tl.sc_ovf;
    fin_nxt.rx         = r[0];
    fin_nxt.ry         = r[1];
    fin_nxt.rz         = r[2];
    fin_nxt.scalar_out = tl.sc;
    fin_nxt.status     = tl.dz ? ST_DZ : (any_ovf ? ST_SAT : ST_OK);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
    end
  end

  assign fin = fin_r;

endmodule

/* sv/vec3_alu.sv */
// channel   | dir | handshake     | payload
// in_if     | in  | valid / ready | func, ax, ay, az, bx, by_comp, bz, scalar_in
// out_if    | out | valid / ready | rx, ry, rz, scalar_out, status
//
// one transaction per cycle sustained while the output is not stalled, Q16.16 at FRAC_BITS = 16
// latency is set by the 32-stage square root and the 32 + FRAC_BITS stage divider,
//   each stage resolving one result bit, the root once for all lanes, the divider in each of the three lanes
// reset (synchronous, active low) clears the stage valids and the skid valid flag only
// an output stall parks the finished transaction in a skid register and the pipe
//   keeps moving that cycle; the pipe then holds until the skid entry drains

`include "vec3_alu_defines.svh"

module vec3_alu import v3alu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  v3alu_in_if.sink     in_if,
  v3alu_out_if.source  out_if
);

  localparam int QW  = DW + FRAC_BITS;
  // input reg, product reg, prep reg, root stages, divider stages, output reg
  localparam int LAT = 3 + SQ_STAGES + QW + 1;

  // global advance: the whole pipe moves unless the skid entry is occupied
  logic           en;
  logic [LAT-1:0] v_r;
  logic           skid_v_r, skid_v_nxt;
  res_t           skid_r, fin_w, out_sel;

  assign en          = !skid_v_r;
  // nothing is taken while reset is held
  assign in_if.ready = en && rst_n;

  // stage 0: operand capture
  logic [3:0]           func0_r;
  logic signed [DW-1:0] a0_r [3];
  logic signed [DW-1:0] b0_r [3];
  logic signed [DW-1:0] s0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      func0_r <= in_if.func;
      a0_r[0] <= in_if.ax;
      a0_r[1] <= in_if.ay;
      a0_r[2] <= in_if.az;
      b0_r[0] <= in_if.bx;
      b0_r[1] <= in_if.by_comp;
      b0_r[2] <= in_if.bz;
      s0_r    <= in_if.scalar_in;
    end
  end

  // one lane per component; cross operands are rotated per lane
  logic signed [2*DW-1:0] p1_w [3];
  lres_t                  lres_w [3];
  logic [DW-1:0]          div_d_w;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3alu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk   (clk),
      .en    (en),
      .func  (func0_r),
      .a_i   (a0_r[i]),
      .b_i   (b0_r[i]),
      .a_j   (a0_r[(i+1)%3]),
      .b_k   (b0_r[(i+2)%3]),
      .a_k   (a0_r[(i+2)%3]),
      .b_j   (b0_r[(i+1)%3]),
      .s     (s0_r),
      .div_d (div_d_w),
      .p1    (p1_w[i]),
      .res   (lres_w[i])
    );
  end

  // shared square root of the sum of squares
  logic [SQ_W-1:0] dotaa_w;
  scal_t           side_to_sqrt, side_from_sqrt;
  logic [DW-1:0]   len_w;

  v3alu_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .n_in     (dotaa_w),
    .side_in  (side_to_sqrt),
    .len_out  (len_w),
    .side_out (side_from_sqrt)
  );

  // dot sum, divisor choice, final lane merge and status
  v3alu_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk    (clk),
    .en     (en),
    .func0  (func0_r),
    .s0     (s0_r),
    .p1     (p1_w),
    .dotaa  (dotaa_w),
    .side_o (side_to_sqrt),
    .len_i  (len_w),
    .side_i (side_from_sqrt),
    .div_d  (div_d_w),
    .lres   (lres_w),
    .fin    (fin_w)
  );

  // skid: fill when the output stage is stalled while the pipe moves,
  // drain when the sink takes it
  assign skid_v_nxt = skid_v_r ? !out_if.ready : (v_r[LAT-1] && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      skid_v_r <= 1'b0;
    end else begin
      if (en) begin
        v_r <= {v_r[LAT-2:0], in_if.valid};
      end
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_r <= fin_w;
    end
  end

  // skid entry is older than the output stage, so it goes first
  assign out_sel           = skid_v_r ? skid_r : fin_w;
  assign out_if.valid      = skid_v_r || v_r[LAT-1];
  assign out_if.rx         = out_sel.rx;
  assign out_if.ry         = out_sel.ry;
  assign out_if.rz         = out_sel.rz;
  assign out_if.scalar_out = out_sel.scalar_out;
  assign out_if.status     = out_sel.status;

  // checks
  logic out_stall, out_all_zero;

  assign out_stall    = out_if.valid && !out_if.ready;
  assign out_all_zero = (out_if.rx == '0) && (out_if.ry == '0) && (out_if.rz == '0)
                        && (out_if.scalar_out == '0);

  `V3A_ASSERT_IMP(a_skid_shown, skid_v_r, out_if.valid, "parked transaction not presented")
  `V3A_ASSERT_IMP(a_dz_zero, out_if.valid && (out_if.status == ST_DZ), out_all_zero, "dz result")
  `V3A_ASSERT_IMP(a_ready_cause, !in_if.ready, $past(out_stall), "input blocked, no stall")
  `V3A_ASSERT_NXT(a_stall_holds, skid_v_r && out_stall, !in_if.ready && out_if.valid, "skid lost")

endmodule
